// ----- sv/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, command codes and phase decode for the I2C master bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  // default width of the phase hold counter
  localparam int TICK_COUNT_WIDTH_DEF = 16;

  // reset value of the phase hold register
  localparam logic [15:0] PHASE_TICKS_RST = 16'd500;

  // mask of the first bit sent or received
  localparam logic [7:0] MSB_MASK = 8'h80;

  // command codes
  localparam logic [2:0] CMD_START    = 3'd0;
  localparam logic [2:0] CMD_STOP     = 3'd1;
  localparam logic [2:0] CMD_WRITE    = 3'd2;
  localparam logic [2:0] CMD_READ     = 3'd3;
  localparam logic [2:0] CMD_SEND_ACK = 3'd4;
  localparam logic [2:0] CMD_RECV_ACK = 3'd5;

  // what one phase does to the pins
  typedef enum logic [2:0] {
    ACT_SDA0,
    ACT_SDA1,
    ACT_SCL0,
    ACT_SCL1,
    ACT_SAMPLE
  } act_t;

  // input beat
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic       sda_in;
  } in_t;

  // result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rx_ack;
  } out_t;

  // number of phases of a command
  function automatic logic [4:0] cmd_len(input logic [2:0] cmd);
    logic [4:0] len;
    unique case (cmd)
      CMD_START:    len = 5'd4;
      CMD_STOP:     len = 5'd3;
      CMD_WRITE:    len = 5'd24;
      CMD_READ:     len = 5'd25;
      CMD_SEND_ACK: len = 5'd3;
      CMD_RECV_ACK: len = 5'd4;
      default:      len = 5'd4;
    endcase
    return len;
  endfunction

  // p / 3 for p below 32, by reciprocal multiply (p * 11 / 32)
  function automatic logic [3:0] div3(input logic [4:0] p);
    logic [8:0] prod;
    prod = {4'd0, p} * 9'd11;
    return prod[8:5];
  endfunction

  // p % 3 from p and its quotient
  function automatic logic [1:0] mod3(input logic [4:0] p, input logic [3:0] q);
    logic [5:0] rem;
    rem = {1'b0, p} - ({2'd0, q} * 6'd3);
    return rem[1:0];
  endfunction

  // pin action of phase p of a command
  function automatic act_t phase_action(input logic [2:0] cmd, input logic [4:0] p,
                                        input logic [7:0] shift, input logic ack_lvl);
    logic [4:0] pm;
    logic [3:0] q;
    logic [1:0] sub;
    act_t       act;
    pm  = (cmd == CMD_READ) ? (p - 5'd1) : p;
    q   = div3(pm);
    sub = mod3(pm, q);
    unique case (cmd)
      CMD_START: begin
        unique case (p[1:0])
          2'd0: act = ACT_SDA1;
          2'd1: act = ACT_SCL1;
          2'd2: act = ACT_SDA0;
          default: act = ACT_SCL0;
        endcase
      end
      CMD_STOP: begin
        priority if (p == 5'd0) act = ACT_SDA0;
        else if (p == 5'd1) act = ACT_SCL1;
        else act = ACT_SDA1;
      end
      CMD_WRITE: begin
        priority if (sub == 2'd0) act = shift[3'd7 - q[2:0]] ? ACT_SDA1 : ACT_SDA0;
        else if (sub == 2'd1) act = ACT_SCL1;
        else act = ACT_SCL0;
      end
      CMD_READ: begin
        priority if (p == 5'd0) act = ACT_SDA1;
        else if (sub == 2'd0) act = ACT_SCL1;
        else if (sub == 2'd1) act = ACT_SAMPLE;
        else act = ACT_SCL0;
      end
      CMD_SEND_ACK: begin
        priority if (p == 5'd0) act = ack_lvl ? ACT_SDA1 : ACT_SDA0;
        else if (p == 5'd1) act = ACT_SCL1;
        else act = ACT_SCL0;
      end
      default: begin
        unique case (p[1:0])
          2'd0: act = ACT_SDA1;
          2'd1: act = ACT_SCL1;
          2'd2: act = ACT_SAMPLE;
          default: act = ACT_SCL0;
        endcase
      end
    endcase
    return act;
  endfunction

  // bit index of a read sample phase
  function automatic logic [2:0] read_bit(input logic [4:0] p);
    logic [3:0] q;
    q = div3(p - 5'd1);
    return q[2:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/i2cm_engine.sv -----
// ----------------------------------------------------------------------------
// i2cm_engine
// Command state, phase sequencing and hold counter; advances one tick per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_engine #(
  parameter int TICK_COUNT_WIDTH = i2cm_pkg::TICK_COUNT_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire i2cm_pkg::in_t in_data,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata,
  output i2cm_pkg::out_t     res
);

  localparam int W  = TICK_COUNT_WIDTH;
  localparam int HW = (W > 16) ? W : 16;

  logic [15:0]  phase_ticks_r;
  logic         scl_r, scl_nxt;
  logic         sda_r, sda_nxt;
  logic [2:0]   cmd_r, cmd_nxt;
  logic         run_r, run_nxt;
  logic [4:0]   pidx_r, pidx_nxt;
  logic [W-1:0] tick_r, tick_nxt;
  logic [7:0]   shift_r, shift_nxt;
  logic         acks_r, acks_nxt;
  logic [7:0]   rxh_r, rxh_nxt;
  logic         ackl_r, ackl_nxt;
  logic         done;

  // phase inputs
  logic          ph_en;
  logic [4:0]    ph_p;
  logic [4:0]    pidx_inc;
  i2cm_pkg::act_t ph_act;

  // hold length, zero treated as one, saturated to the counter
  logic [15:0]   hold16;
  logic [HW-1:0] hold_ext;
  logic [HW-1:0] hold_max;
  logic [HW-1:0] hold_sat;

  assign hold16   = (phase_ticks_r == 16'd0) ? 16'd0 : (phase_ticks_r - 16'd1);
  assign hold_ext = HW'(hold16);
  assign hold_max = HW'({W{1'b1}});
  assign hold_sat = (hold_ext > hold_max) ? hold_max : hold_ext;

  assign pidx_inc = pidx_r + 5'd1;

  // next state for one tick
  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    cmd_nxt   = cmd_r;
    run_nxt   = run_r;
    pidx_nxt  = pidx_r;
    tick_nxt  = tick_r;
    shift_nxt = shift_r;
    acks_nxt  = acks_r;
    rxh_nxt   = rxh_r;
    ackl_nxt  = ackl_r;
    done      = 1'b0;
    ph_en     = 1'b0;
    ph_p      = pidx_inc;
    if (run_r) begin
      if (tick_r != '0) begin
        tick_nxt = tick_r - W'(1);
      end else if (pidx_inc >= i2cm_pkg::cmd_len(cmd_r)) begin
        run_nxt  = 1'b0;
        done     = 1'b1;
        pidx_nxt = 5'd0;
        if (cmd_r == i2cm_pkg::CMD_READ) rxh_nxt = shift_r;
      end else begin
        pidx_nxt = pidx_inc;
        ph_en    = 1'b1;
      end
    end else if (in_data.cmd_valid && (in_data.mode <= i2cm_pkg::CMD_RECV_ACK)) begin
      cmd_nxt   = in_data.mode;
      run_nxt   = 1'b1;
      pidx_nxt  = 5'd0;
      shift_nxt = (in_data.mode == i2cm_pkg::CMD_WRITE) ? in_data.tx_byte : 8'd0;
      ackl_nxt  = in_data.ack_out;
      ph_en     = 1'b1;
      ph_p      = 5'd0;
    end

    // run the phase just entered
    ph_act = i2cm_pkg::phase_action(cmd_nxt, ph_p, shift_nxt, ackl_nxt);
    if (ph_en) begin
      tick_nxt = hold_sat[W-1:0];
      unique case (ph_act)
        i2cm_pkg::ACT_SDA0: sda_nxt = 1'b0;
        i2cm_pkg::ACT_SDA1: sda_nxt = 1'b1;
        i2cm_pkg::ACT_SCL0: scl_nxt = 1'b0;
        i2cm_pkg::ACT_SCL1: scl_nxt = 1'b1;
        default: begin
          if (cmd_nxt == i2cm_pkg::CMD_READ) begin
            if (in_data.sda_in)
              shift_nxt = shift_nxt | (i2cm_pkg::MSB_MASK >> i2cm_pkg::read_bit(ph_p));
          end else begin
            acks_nxt = in_data.sda_in;
          end
        end
      endcase
    end
  end

  // result of this tick
  always_comb begin
    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.busy_res  = run_nxt;
    res.done_res  = done;
    res.rx_byte   = rxh_nxt;
    res.rx_ack    = acks_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cm_pkg::PHASE_TICKS_RST;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      cmd_r   <= i2cm_pkg::CMD_START;
      run_r   <= 1'b0;
      pidx_r  <= 5'd0;
      tick_r  <= '0;
      shift_r <= 8'd0;
      acks_r  <= 1'b1;
      rxh_r   <= 8'd0;
      ackl_r  <= 1'b1;
    end else begin
      if (cfg_we) phase_ticks_r <= cfg_wdata;
      if (step) begin
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        cmd_r   <= cmd_nxt;
        run_r   <= run_nxt;
        pidx_r  <= pidx_nxt;
        tick_r  <= tick_nxt;
        shift_r <= shift_nxt;
        acks_r  <= acks_nxt;
        rxh_r   <= rxh_nxt;
        ackl_r  <= ackl_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/i2c_master_bit_engine.sv -----
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Open-drain I2C master primitive engine with a two-entry result buffer.
// ----------------------------------------------------------------------------
// Every input beat is one tick of bus timing and yields exactly one result beat
// carrying the SCL/SDA drive levels, busy/done flags, last read byte and last
// sampled ack. A beat is taken every cycle unless a result waits in the skid
// register: the tick is worked out in combinational next-state logic, and its
// result is registered at the accepting edge into the output register or, while
// a result waits there, into the skid register behind it. Each command phase is
// held phase_ticks ticks (zero counts as one), so a command lasts its phase
// count times that hold plus one finishing tick. Commands given while busy are
// dropped. Write phase_ticks only while idle.
`default_nettype none

module i2c_master_bit_engine #(
  parameter int TICK_COUNT_WIDTH = i2cm_pkg::TICK_COUNT_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire i2cm_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output i2cm_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [15:0]    cfg_wdata
);

  logic           push;
  logic           pop;
  i2cm_pkg::out_t res;
  logic           head_v_r;
  i2cm_pkg::out_t head_r;
  logic           skid_v_r;
  i2cm_pkg::out_t skid_r;

  assign in_ready  = !skid_v_r;
  assign push      = in_valid && in_ready;
  assign pop       = head_v_r && out_ready;
  assign out_valid = head_v_r;
  assign out_data  = head_r;

  // tick logic
  i2cm_engine #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (push),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  // result buffer: head register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop || !head_v_r) begin
        if (skid_v_r) begin
          head_v_r <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          head_v_r <= push;
        end
      end else if (push) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop || !head_v_r) begin
      head_r <= skid_v_r ? skid_r : res;
    end else if (push) begin
      skid_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- sv/i2cm_checker.sv -----
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire i2cm_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire i2cm_pkg::out_t out_data
);

  // no result beat pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat pending after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // a waiting input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting input beat changed");

  // input only backs up when a result is waiting
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // a finishing beat is never busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done and busy on one beat");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);

`default_nettype wire
